// File: design/task_queue_with_sleep_release_top_defines.svh
// Assertion macros used by the sleep queue top level.
`ifndef TASK_QUEUE_WITH_SLEEP_RELEASE_TOP_DEFINES_SVH
`define TASK_QUEUE_WITH_SLEEP_RELEASE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TQSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TQSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tqsr_pkg.sv
// Shared types and constants for the sleep queue with tick release.
package tqsr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 16;
  localparam int TICKS_W         = 16;
  localparam int LEN_W           = 5;

  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [ID_W-1:0]    task_id;
    logic [TICKS_W-1:0] sleep_ticks;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  released_id;
    logic             id_valid;
    logic             last;
    logic [LEN_W-1:0] queue_length;
    logic             overflow;
  } out_item_t;

  // One queue slot as it sits in memory.
  typedef struct packed {
    logic [ID_W-1:0]    task_id;
    logic [TICKS_W-1:0] sleep;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// File: design/task_queue_with_sleep_release_top.sv
// Top level of the sleep queue: ring buffer in RAM, put/get/tick sequencer and result register.
//
// Usage:
// - Input channel (in_valid, in_ready, in_item): one operation per item, put, get or tick.
//   Items are taken one at a time; in_ready is high only while no operation is in work.
// - Result channel (out_valid, out_ready, out_item): put, get and unused codes give one
//   result; a tick gives one result per released task in queue order, or one empty result
//   when nothing is released. The final result of an item carries last = 1.
// - Put and unused codes go straight to the emit state; get first reads the head slot. The
//   result is registered from the emit state once the output register is free.
// - A tick on a held queue runs two passes: the single RAM read port visits every held slot
//   twice, once to count releases (which fixes queue_length for all of the tick's results)
//   and once to decrement and compact the survivors toward the head.
// - A result waits in the output register while out_ready is low; during a tick the compact
//   pass pauses on a released slot until the register is free, so no result is lost.
// - Reset (rst_n low, synchronous) empties the queue and drops any result in flight. Slot
//   contents are not cleared; only slots below the held count are ever read.
`include "task_queue_with_sleep_release_top_defines.svh"

module task_queue_with_sleep_release_top
  import tqsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EMIT = 3'd1;
  localparam logic [2:0] ST_GET  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_COMP = 3'd4;

  logic [2:0]    state_r,   state_nxt;
  logic [AW-1:0] head_r,    head_nxt;
  logic [CW-1:0] count_r,   count_nxt;
  logic [CW-1:0] rd_idx_r,  rd_idx_nxt;
  logic [CW-1:0] keep_r,    keep_nxt;
  logic [CW-1:0] relcnt_r,  relcnt_nxt;
  logic [CW-1:0] emitted_r, emitted_nxt;
  logic [CW-1:0] new_len_r, new_len_nxt;
  out_item_t     pend_r,    pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r,  out_item_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  slot_t             ram_wslot, ram_rslot;
  logic [SLOT_W-1:0] ram_rdata;

  logic          out_free;
  logic          rel_hit;
  logic          last_entry;
  logic [CW-1:0] rel_sum;

  // Ring address: base plus offset, wrapped once at the depth.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] to_len(input logic [CW-1:0] c);
    logic [CW+LEN_W-1:0] e;
    e = {{LEN_W{1'b0}}, c};
    return e[LEN_W-1:0];
  endfunction

  tqsr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_rslot  = slot_t'(ram_rdata);
  assign out_free   = !out_valid_r || out_ready;
  assign rel_hit    = (ram_rslot.sleep <= TICKS_W'(1));
  assign last_entry = (rd_idx_r == count_r);
  assign rel_sum    = relcnt_r + CW'(rel_hit);
  assign in_ready   = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    keep_nxt      = keep_r;
    relcnt_nxt    = relcnt_r;
    emitted_nxt   = emitted_r;
    new_len_nxt   = new_len_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = ring_add(head_r, keep_r);
    ram_wslot     = '{task_id: ram_rslot.task_id, sleep: ram_rslot.sleep - TICKS_W'(1)};
    ram_re        = 1'b0;
    ram_raddr     = ring_add(head_r, rd_idx_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pend_nxt = '{released_id: '0, id_valid: 1'b0, last: 1'b1,
                       queue_length: to_len(count_r), overflow: 1'b0};
          state_nxt = ST_EMIT;
          unique case (in_item.operation)
            OP_PUT: begin
              if (count_r >= DEPTH_C) begin
                pend_nxt.overflow = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(head_r, count_r);
                ram_wslot = '{task_id: in_item.task_id, sleep: in_item.sleep_ticks};
                count_nxt = count_r + CW'(1);
                pend_nxt.queue_length = to_len(count_r + CW'(1));
              end
            end
            OP_GET: begin
              if (count_r != '0) begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                state_nxt = ST_GET;
              end
            end
            OP_TICK: begin
              if (count_r != '0) begin
                ram_re     = 1'b1;
                ram_raddr  = head_r;
                rd_idx_nxt = CW'(1);
                relcnt_nxt = '0;
                state_nxt  = ST_SCAN;
              end
            end
            default: begin
              // Unused code: report the length, change nothing.
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = pend_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_GET: begin
        pend_nxt = '{released_id: ram_rslot.task_id, id_valid: 1'b1, last: 1'b1,
                     queue_length: to_len(count_r - CW'(1)), overflow: 1'b0};
        head_nxt  = ring_add(head_r, CW'(1));
        count_nxt = count_r - CW'(1);
        state_nxt = ST_EMIT;
      end

      ST_SCAN: begin
        // First pass only counts releases, so every result of the tick knows the final length.
        relcnt_nxt = rel_sum;
        ram_re     = 1'b1;
        if (last_entry) begin
          new_len_nxt = count_r - rel_sum;
          ram_raddr   = head_r;
          rd_idx_nxt  = CW'(1);
          keep_nxt    = '0;
          emitted_nxt = '0;
          state_nxt   = ST_COMP;
        end else begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
      end

      ST_COMP: begin
        // A released slot waits here until the output register can take it; the read data
        // holds because no new read is issued while stalled.
        if (!rel_hit || out_free) begin
          if (rel_hit) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{released_id: ram_rslot.task_id, id_valid: 1'b1,
                              last: (emitted_r + CW'(1) == relcnt_r),
                              queue_length: to_len(new_len_r), overflow: 1'b0};
            emitted_nxt   = emitted_r + CW'(1);
          end else begin
            ram_we   = 1'b1;
            keep_nxt = keep_r + CW'(1);
          end
          if (last_entry) begin
            count_nxt = new_len_r;
            if (relcnt_r == '0) begin
              pend_nxt = '{released_id: '0, id_valid: 1'b0, last: 1'b1,
                           queue_length: to_len(new_len_r), overflow: 1'b0};
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            ram_re     = 1'b1;
            rd_idx_nxt = rd_idx_r + CW'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    keep_r     <= keep_nxt;
    relcnt_r   <= relcnt_nxt;
    emitted_r  <= emitted_nxt;
    new_len_r  <= new_len_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TQSR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= DEPTH_C, "held count exceeds queue depth")
  `TQSR_ASSERT_NOW(a_no_rw_overlap, ram_we && ram_re && (state_r == ST_COMP),
    ram_waddr != ram_raddr, "compaction write hits the slot being read")
  `TQSR_ASSERT_NOW(a_emit_bound, state_r == ST_COMP, emitted_r < relcnt_r
    || (emitted_r == relcnt_r && !(rel_hit)), "more releases than counted")
  `TQSR_ASSERT_NEXT(a_comp_length, (state_r == ST_COMP) && (state_nxt != ST_COMP),
    count_r == keep_r, "survivor count differs from counted length")

endmodule

// File: design/tqsr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tqsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
